FILE: rtl/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds in the same cycle
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// condition holds in the next cycle
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: rtl/epdq_pkg.sv
`timescale 1ns / 1ps
package epdq_pkg;

    localparam int DEPTH    = 16;
    localparam int TAG_BITS = 16;
    localparam int TAG_W    = 16;
    localparam int LIM_W    = 5;
    localparam int OCC_W    = 5;
    localparam int CNT_W    = $clog2(DEPTH + 1);
    localparam int IDX_W    = $clog2(DEPTH);
    localparam int CMP_W    = (CNT_W > LIM_W) ? CNT_W : LIM_W;

    localparam logic [LIM_W-1:0] SOFT_LIMIT_RESET = LIM_W'(8);

    typedef enum logic
    {
        CMD_ENQ = 1'b0,
        CMD_DEQ = 1'b1
    } cmd_t;

    typedef enum logic [1:0]
    {
        S_IDLE,
        S_SCAN,
        S_APPEND,
        S_DONE
    } state_t;

    typedef struct packed
    {
        logic [TAG_BITS-1:0] tag;
        logic                ev;
    } entry_t;

    typedef struct packed
    {
        logic shift_en;
        logic load_en;
    } cell_ctrl_t;

    typedef struct packed
    {
        logic             out_valid;
        logic [TAG_W-1:0] out_tag;
        logic             out_is_event;
        logic             dropped_valid;
        logic [TAG_W-1:0] dropped_tag;
        logic             rejected;
        logic [OCC_W-1:0] occupancy;
    } result_t;

endpackage

FILE: rtl/epdq_in_if.sv
`timescale 1ns / 1ps
interface epdq_in_if import epdq_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             command;
    logic [TAG_W-1:0] packet_tag;
    logic             is_event;

    modport source (output valid, command, packet_tag, is_event, input ready);
    modport sink   (input valid, command, packet_tag, is_event, output ready);
endinterface

FILE: rtl/epdq_out_if.sv
`timescale 1ns / 1ps
interface epdq_out_if import epdq_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             out_valid;
    logic [TAG_W-1:0] out_tag;
    logic             out_is_event;
    logic             dropped_valid;
    logic [TAG_W-1:0] dropped_tag;
    logic             rejected;
    logic [OCC_W-1:0] occupancy;

    modport source (output valid, out_valid, out_tag, out_is_event, dropped_valid,
                    dropped_tag, rejected, occupancy, input ready);
    modport sink   (input valid, out_valid, out_tag, out_is_event, dropped_valid,
                    dropped_tag, rejected, occupancy, output ready);
endinterface

FILE: rtl/epdq_cfg_if.sv
`timescale 1ns / 1ps
interface epdq_cfg_if import epdq_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [LIM_W-1:0] soft_limit;

    modport source (output valid, soft_limit, input ready);
    modport sink   (input valid, soft_limit, output ready);
endinterface

FILE: rtl/event_protecting_drop_queue_core.sv
`timescale 1ns / 1ps
// dequeue: the row of cells shifts once toward the head; the result goes out via S_DONE
// enqueue: the row rotates once per held entry; at soft limit the oldest non-event frame drops
// one word in flight at a time; the next word is taken once the result is registered
// async active-low reset: queue empty, soft limit 8, no result pending
module event_protecting_drop_queue_core import epdq_pkg::*;
`include "assert_macros.svh"
(
    input  logic       clk,
    input  logic       rst_n,
    epdq_cfg_if.sink   cfg,
    epdq_in_if.sink    req,
    epdq_out_if.source rsp
);

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    count_reg;
    logic [LIM_W-1:0]    soft_limit_reg;
    logic [IDX_W-1:0]    step_reg;
    logic [TAG_BITS-1:0] tag_reg;
    logic                ev_reg;
    logic                drop_en_reg;
    logic                found_reg;
    logic [TAG_BITS-1:0] drop_tag_reg;
    result_t             res_reg;
    result_t             out_data_reg;
    logic                out_full_reg;

    entry_t              cells    [DEPTH];
    cell_ctrl_t          ctrls    [DEPTH];
    logic                shift_all;
    logic                load_any;
    logic [CNT_W-1:0]    load_idx;
    entry_t              load_data;
    logic                acc;
    logic                is_deq;
    logic                drop_now;
    logic                out_free;
    logic                limit_hit;
    logic [CNT_W-1:0]    count_eff;
    logic [CNT_W-1:0]    count_m1;
    logic [IDX_W-1:0]    last_step;
    entry_t              head;

    assign head      = cells[0];
    assign acc       = req.valid && req.ready;
    assign is_deq    = (cmd_t'(req.command) == CMD_DEQ);
    assign drop_now  = drop_en_reg && !found_reg && !head.ev;
    assign out_free  = !out_full_reg || rsp.ready;
    assign limit_hit = CMP_W'(count_reg) >= CMP_W'(soft_limit_reg);
    assign count_eff = count_reg - CNT_W'(found_reg);
    assign count_m1  = count_reg - CNT_W'(1);
    assign last_step = count_m1[IDX_W-1:0];
    assign cfg.ready = 1'b1;

    // cell row
    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            entry_t nb;
            if (gi == DEPTH - 1)
            begin : g_last
                assign nb = cells[gi];
            end
            else
            begin : g_mid
                assign nb = cells[gi+1];
            end
            assign ctrls[gi].shift_en = shift_all;
            assign ctrls[gi].load_en  = load_any && (load_idx == CNT_W'(gi));
            epdq_cell u_cell
            (
                .clk        (clk),
                .ctrl       (ctrls[gi]),
                .load_data  (load_data),
                .shift_data (nb),
                .data       (cells[gi])
            );
        end
    endgenerate

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (acc)
                begin
                    if (is_deq)
                    begin
                        state_next = S_DONE;
                    end
                    else if (count_reg == '0)
                    begin
                        state_next = S_APPEND;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                if (step_reg == last_step)
                begin
                    state_next = S_APPEND;
                end
            end
            S_APPEND:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        req.ready = 1'b0;
        shift_all = 1'b0;
        load_any  = 1'b0;
        load_idx  = '0;
        load_data = head;
        case (state_reg)
            S_IDLE:
            begin
                req.ready = 1'b1;
                shift_all = req.valid && is_deq && (count_reg != '0);
            end
            S_SCAN:
            begin
                shift_all = 1'b1;
                load_any  = !drop_now;
                load_idx  = found_reg ? (count_m1 - CNT_W'(1)) : count_m1;
            end
            S_APPEND:
            begin
                load_any  = count_eff < CNT_W'(DEPTH);
                load_idx  = count_eff;
                load_data = '{tag: tag_reg, ev: ev_reg};
            end
            S_DONE:
            begin
                req.ready = 1'b0;
            end
            default:
            begin
                req.ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            soft_limit_reg <= SOFT_LIMIT_RESET;
            step_reg       <= '0;
            drop_en_reg    <= 1'b0;
            found_reg      <= 1'b0;
            out_full_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg.valid && cfg.ready)
            begin
                soft_limit_reg <= cfg.soft_limit;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (acc)
                    begin
                        step_reg    <= '0;
                        found_reg   <= 1'b0;
                        drop_en_reg <= limit_hit && !is_deq;
                        if (is_deq && (count_reg != '0))
                        begin
                            count_reg <= count_m1;
                        end
                    end
                end
                S_SCAN:
                begin
                    step_reg <= step_reg + IDX_W'(1);
                    if (drop_now)
                    begin
                        found_reg <= 1'b1;
                    end
                end
                S_APPEND:
                begin
                    if (count_eff < CNT_W'(DEPTH))
                    begin
                        count_reg <= count_eff + CNT_W'(1);
                    end
                    else
                    begin
                        count_reg <= count_eff;
                    end
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        out_full_reg <= 1'b1;
                    end
                end
                default:
                begin
                    step_reg <= '0;
                end
            endcase
            if (rsp.ready && !(state_reg == S_DONE))
            begin
                out_full_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && acc)
        begin
            tag_reg <= req.packet_tag[TAG_BITS-1:0];
            ev_reg  <= req.is_event;
            if (is_deq && (count_reg != '0))
            begin
                res_reg <= '{out_valid: 1'b1, out_tag: TAG_W'(head.tag),
                             out_is_event: head.ev, dropped_valid: 1'b0,
                             dropped_tag: '0, rejected: 1'b0,
                             occupancy: OCC_W'(count_m1)};
            end
            else
            begin
                res_reg <= '{out_valid: 1'b0, out_tag: '0, out_is_event: 1'b0,
                             dropped_valid: 1'b0, dropped_tag: '0, rejected: 1'b0,
                             occupancy: OCC_W'(count_reg)};
            end
        end
        if (state_reg == S_SCAN && drop_now)
        begin
            drop_tag_reg <= head.tag;
        end
        if (state_reg == S_APPEND)
        begin
            res_reg <= '{out_valid: 1'b0, out_tag: '0, out_is_event: 1'b0,
                         dropped_valid: found_reg,
                         dropped_tag: found_reg ? TAG_W'(drop_tag_reg) : '0,
                         rejected: count_eff >= CNT_W'(DEPTH),
                         occupancy: (count_eff < CNT_W'(DEPTH)) ?
                                    OCC_W'(count_eff + CNT_W'(1)) : OCC_W'(count_eff)};
        end
        if (state_reg == S_DONE && out_free)
        begin
            out_data_reg <= res_reg;
        end
    end

    assign rsp.valid         = out_full_reg;
    assign rsp.out_valid     = out_data_reg.out_valid;
    assign rsp.out_tag       = out_data_reg.out_tag;
    assign rsp.out_is_event  = out_data_reg.out_is_event;
    assign rsp.dropped_valid = out_data_reg.dropped_valid;
    assign rsp.dropped_tag   = out_data_reg.dropped_tag;
    assign rsp.rejected      = out_data_reg.rejected;
    assign rsp.occupancy     = out_data_reg.occupancy;

    `ASSERT_SAME(a_count_max, clk, rst_n, 1'b1, count_reg <= CNT_W'(DEPTH))
    `ASSERT_SAME(a_drop_gated, clk, rst_n, found_reg, drop_en_reg)
    `ASSERT_NEXT(a_busy_after_acc, clk, rst_n, acc, state_reg != S_IDLE)
    `ASSERT_NEXT(a_deq_empty_keeps, clk, rst_n, acc && is_deq && (count_reg == '0),
                 count_reg == '0)

endmodule

FILE: rtl/epdq_cell.sv
`timescale 1ns / 1ps
module epdq_cell import epdq_pkg::*;
(
    input  logic       clk,
    input  cell_ctrl_t ctrl,
    input  entry_t     load_data,
    input  entry_t     shift_data,
    output entry_t     data
);

    entry_t data_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.load_en)
        begin
            data_reg <= load_data;
        end
        else if (ctrl.shift_en)
        begin
            data_reg <= shift_data;
        end
    end

    assign data = data_reg;

endmodule
